FILE: hdl/urhs_pkg.sv
// Shared types and codes for the undo/redo history stacks.
// No dependencies; imported by every module of the block except urhs_stack.
package urhs_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_SAVE = 2'd0,
    REQ_UNDO = 2'd1,
    REQ_REDO = 2'd2
  } req_e;

  // Controller states
  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_RESPOND = 1'b1
  } state_e;

  // Input item
  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] current_value;
  } req_t;

  // Result item
  typedef struct packed {
    logic [63:0] new_value;
    logic        status;
    logic [6:0]  undo_depth;
    logic [6:0]  redo_depth;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;
    logic respond;
  } ctrl_cmd_t;

endpackage

FILE: hdl/urhs_stack.sv
// One bounded history stack: ring memory with head pointer and fill count.
// Depends on nothing outside this file.
module urhs_stack #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic             clear_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic [FW-1:0]    fill_o
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FullCnt = FW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW-1:0]    head_q, head_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    head_inc, head_dec;

  // Ring neighbours of the head
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? LastIdx : head_q - AW'(1);

  // Advance head and fill
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (push_i) begin
      head_d = head_inc;
      if (fill_q != FullCnt) begin
        fill_d = fill_q + FW'(1);
      end
    end else if (pop_i) begin
      head_d = head_dec;
      if (fill_q != '0) begin
        fill_d = fill_q - FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // Write the pushed word at the head; an overwrite on full drops the oldest
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[head_q] <= wdata_i;
    end
  end

  // Read the top entry on a pop
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem_q[head_dec];
    end
  end

  assign rdata_o = rdata_q;
  assign fill_o  = fill_q;

endmodule

FILE: hdl/urhs_datapath.sv
// Datapath: request decode, the undo and redo stacks, and result assembly.
// Depends on urhs_pkg and urhs_stack.
module urhs_datapath #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  urhs_pkg::ctrl_cmd_t cmd_i,
  input  urhs_pkg::req_t    req_i,
  output urhs_pkg::rsp_t    rsp_o
);
  import urhs_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] cur_word;
  logic [WIDTH-1:0] cur_q;
  logic             status_q;
  logic             sel_undo_q, sel_redo_q;

  logic undo_push, undo_pop, redo_push, redo_pop, redo_clear;
  logic status_d;

  logic [WIDTH-1:0] undo_rdata, redo_rdata;
  logic [FW-1:0]    undo_fill, redo_fill;

  logic [WIDTH-1:0]    res_word;
  logic [WIDTH+63:0]   res_ext;
  logic [FW+6:0]       undo_ext, redo_ext;

  assign cur_word = req_i.current_value[WIDTH-1:0];

  // Decode the request into stack operations
  always_comb begin
    undo_push  = 1'b0;
    undo_pop   = 1'b0;
    redo_push  = 1'b0;
    redo_pop   = 1'b0;
    redo_clear = 1'b0;
    status_d   = 1'b0;
    if (cmd_i.exec) begin
      unique case (req_i.req_type)
        REQ_SAVE: begin
          redo_clear = 1'b1;
          undo_push  = 1'b1;
        end
        REQ_UNDO: begin
          if (undo_fill == '0) begin
            status_d = 1'b1;
          end else begin
            redo_push = 1'b1;
            undo_pop  = 1'b1;
          end
        end
        REQ_REDO: begin
          if (redo_fill == '0) begin
            status_d = 1'b1;
          end else begin
            undo_push = 1'b1;
            redo_pop  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  urhs_stack #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_undo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (undo_push),
    .pop_i   (undo_pop),
    .clear_i (1'b0),
    .wdata_i (cur_word),
    .rdata_o (undo_rdata),
    .fill_o  (undo_fill)
  );

  urhs_stack #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_redo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (redo_push),
    .pop_i   (redo_pop),
    .clear_i (redo_clear),
    .wdata_i (cur_word),
    .rdata_o (redo_rdata),
    .fill_o  (redo_fill)
  );

  // Hold the request outcome for the response cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cur_q      <= cur_word;
      status_q   <= status_d;
      sel_undo_q <= undo_pop;
      sel_redo_q <= redo_pop;
    end
  end

  // Assemble the result from the popped word or the held value
  always_comb begin
    if (sel_undo_q) begin
      res_word = undo_rdata;
    end else if (sel_redo_q) begin
      res_word = redo_rdata;
    end else begin
      res_word = cur_q;
    end
  end

  assign res_ext  = {64'd0, res_word};
  assign undo_ext = {7'd0, undo_fill};
  assign redo_ext = {7'd0, redo_fill};

  always_comb begin
    rsp_o = '0;
    if (cmd_i.respond) begin
      rsp_o.new_value  = res_ext[63:0];
      rsp_o.status     = status_q;
      rsp_o.undo_depth = undo_ext[6:0];
      rsp_o.redo_depth = redo_ext[6:0];
    end
  end

endmodule

FILE: hdl/urhs_ctrl.sv
// Controller: two-state sequencer that accepts a request and strobes its result.
// Depends on urhs_pkg.
module urhs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                valid_o,
  output urhs_pkg::ctrl_cmd_t cmd_o
);
  import urhs_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RESPOND;
        end
      end
      ST_RESPOND: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b0;
    valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.exec = start_i;
      end
      ST_RESPOND: begin
        busy_o        = 1'b1;
        valid_o       = 1'b1;
        cmd_o.respond = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/undo_redo_history_stacks_core.sv
// Top level of the undo/redo history stacks.
// Depends on urhs_pkg, urhs_ctrl and urhs_datapath.
//
// Each request is accepted when start_i is high and busy_o low; the stack
// memories are updated and the popped entry is read in that cycle, and the
// result is strobed on result_valid_o for exactly one cycle in the next,
// while busy_o is high. A popped result comes from the registered read port
// of the stack memories; a new request can follow in the cycle after the
// strobe. The receiver cannot stall: every result must be taken in its
// strobe cycle. No clearing pass follows reset; each stack starts empty
// through its fill count.
module undo_redo_history_stacks_core #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  urhs_pkg::req_t req_i,
  output logic           result_valid_o,
  output urhs_pkg::rsp_t result_o
);
  import urhs_pkg::*;

  ctrl_cmd_t cmd;

  urhs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .valid_o (result_valid_o),
    .cmd_o   (cmd)
  );

  urhs_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (result_o)
  );

endmodule
